[rtl/bpa_pkg.sv]
// shared types and constants for the buddy page allocator
// used by bpa_ctrl, bpa_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int ORDERS     = 16;
    localparam int ORD_W      = 4;
    localparam int IDX_W      = ORDERS;          // region holds 2^(ORDERS) frames
    localparam int FRAMES     = 1 << IDX_W;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 17;
    localparam int SPAN_W     = IDX_W + PAGE_SHIFT;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_INIT_A,
        OP_INIT_F,
        OP_RD_IDX,
        OP_RD_BUD,
        OP_SCAN_NEXT,
        OP_SPLIT,
        OP_ALLOC_FIN,
        OP_FREE_CLR,
        OP_MERGE,
        OP_FREE_FIN,
        OP_FAIL
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NO_BLOCK  = 2'd1,
        ERR_BAD_ADDR  = 2'd2,
        ERR_NOT_ALLOC = 2'd3
    } t_err;

    typedef struct packed {
        t_op  op;
        t_err err;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic act;
        logic cnt_bad;
        logic addr_bad;
        logic hit;
        logic scan_last;
        logic split_done;
        logic used;
        logic top_max;
    } t_sts;

    typedef struct packed {
        logic             head;
        logic             used;
        logic [ORD_W-1:0] order;
    } t_ent;

endpackage

`default_nettype wire

[rtl/bpa_dp.sv]
// datapath: frame state memory, scan and split/merge registers, result registers
// depends on bpa_pkg; driven by bpa_ctrl
`timescale 1ns / 1ps
`default_nettype none

module bpa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_cmd                 i_cmd,
    output bpa_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  logic                          i_act,
    input  logic [bpa_pkg::CNT_W-1:0]     i_cnt,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_addr,
    output logic                          o_ok,
    output logic [1:0]                    o_err,
    output logic [bpa_pkg::ADDR_W-1:0]    o_baddr,
    output logic [bpa_pkg::ORD_W-1:0]     o_bord
);
    import bpa_pkg::*;

    t_ent                r_mem [FRAMES];
    t_ent                r_rd;
    logic [ADDR_W-1:0]   r_base;
    logic [IDX_W:0]      r_clr;
    logic                r_act;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]   r_addr;
    logic [ORD_W-1:0]    r_want;
    logic [ORD_W-1:0]    r_top;
    logic [IDX_W-1:0]    r_idx;
    logic                r_ok;
    logic [1:0]          r_err;
    logic [ADDR_W-1:0]   r_baddr;
    logic [ORD_W-1:0]    r_bord;

    logic [IDX_W:0]      step_sum;
    logic [IDX_W-1:0]    buddy;
    logic [IDX_W-1:0]    split_bud;
    logic [ORD_W-1:0]    top_dn;
    logic [ADDR_W-1:0]   off;
    logic [CNT_W-1:0]    cnt_m1;
    logic [ORD_W-1:0]    want;
    logic                wen;
    logic [IDX_W-1:0]    waddr;
    t_ent                wdata;
    logic                ren;
    logic [IDX_W-1:0]    raddr;
    logic                carve_head;

    assign top_dn    = r_top - ORD_W'(1);
    assign step_sum  = {1'b0, r_idx} + ((IDX_W+1)'(1) << r_top);
    assign buddy     = r_idx ^ (IDX_W'(1) << r_top);
    assign split_bud = r_idx ^ (IDX_W'(1) << top_dn);
    assign off       = r_addr - r_base;
    assign cnt_m1    = r_cnt - CNT_W'(1);
    // carving of a 2^ORDERS frame region gives blocks of the top order only
    assign carve_head = (r_clr[IDX_W-2:0] == '0);

    // round the page count up to a power of two
    always_comb begin
        want = '0;
        for (int i = 0; i < ORDERS - 1; i++) begin
            if (cnt_m1[i]) want = ORD_W'(i + 1);
        end
    end

    always_comb begin
        o_sts.clr_done   = r_clr[IDX_W];
        o_sts.act        = r_act;
        o_sts.cnt_bad    = (r_cnt == '0) || (r_cnt > (CNT_W'(1) << (ORDERS - 1)));
        o_sts.addr_bad   = (r_addr < r_base) || (off[ADDR_W-1:SPAN_W] != '0)
                           || (off[PAGE_SHIFT-1:0] != '0);
        o_sts.hit        = r_rd.head && (r_rd.order == r_top);
        o_sts.scan_last  = step_sum[IDX_W] && (r_top == ORD_W'(ORDERS - 1));
        o_sts.split_done = (r_top == r_want);
        o_sts.used       = r_rd.used;
        o_sts.top_max    = (r_top == ORD_W'(ORDERS - 1));
    end

    always_comb begin
        wen   = 1'b0;
        waddr = r_idx;
        wdata = r_rd;
        ren   = 1'b0;
        raddr = r_idx;
        unique case (i_cmd.op)
            OP_CLR: begin
                wen   = 1'b1;
                waddr = r_clr[IDX_W-1:0];
                wdata = '{head: carve_head, used: 1'b0,
                          order: carve_head ? ORD_W'(ORDERS - 1) : '0};
            end
            OP_RD_IDX: ren = 1'b1;
            OP_RD_BUD: begin
                ren   = 1'b1;
                raddr = buddy;
            end
            OP_SPLIT: begin
                wen   = 1'b1;
                waddr = split_bud;
                wdata = '{head: 1'b1, used: 1'b0, order: top_dn};
            end
            OP_ALLOC_FIN: begin
                wen   = 1'b1;
                wdata = '{head: 1'b0, used: 1'b1, order: r_want};
            end
            OP_FREE_CLR: begin
                wen   = 1'b1;
                wdata = '{head: 1'b0, used: 1'b0, order: r_rd.order};
            end
            OP_MERGE: begin
                wen   = 1'b1;
                waddr = buddy;
                wdata = '{head: 1'b0, used: r_rd.used, order: r_rd.order};
            end
            OP_FREE_FIN: begin
                wen   = 1'b1;
                wdata = '{head: 1'b1, used: 1'b0, order: r_top};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wen) r_mem[waddr] <= wdata;
        if (ren) r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_clr  <= '0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_wdata;
            if (i_cmd.op == OP_CLR) r_clr <= r_clr + (IDX_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_act  <= i_act;
                r_cnt  <= i_cnt;
                r_addr <= i_addr;
            end
            OP_INIT_A: begin
                r_want <= want;
                r_top  <= want;
                r_idx  <= '0;
            end
            OP_INIT_F: r_idx <= off[SPAN_W-1:PAGE_SHIFT];
            OP_SCAN_NEXT: begin
                r_idx <= step_sum[IDX_W-1:0];
                if (step_sum[IDX_W]) r_top <= r_top + ORD_W'(1);
            end
            OP_SPLIT:    r_top <= top_dn;
            OP_FREE_CLR: r_top <= r_rd.order;
            OP_MERGE: begin
                r_idx <= r_idx & buddy;
                r_top <= r_top + ORD_W'(1);
            end
            OP_ALLOC_FIN: begin
                r_ok    <= 1'b1;
                r_err   <= ERR_NONE;
                r_baddr <= r_base + {{(ADDR_W-SPAN_W){1'b0}}, r_idx, {PAGE_SHIFT{1'b0}}};
                r_bord  <= r_want;
            end
            OP_FREE_FIN: begin
                r_ok    <= 1'b1;
                r_err   <= ERR_NONE;
                r_baddr <= '0;
                r_bord  <= '0;
            end
            OP_FAIL: begin
                r_ok    <= 1'b0;
                r_err   <= i_cmd.err;
                r_baddr <= '0;
                r_bord  <= '0;
            end
            default: ;
        endcase
    end

    assign o_ok    = r_ok;
    assign o_err   = r_err;
    assign o_baddr = r_baddr;
    assign o_bord  = r_bord;

endmodule

`default_nettype wire

[rtl/bpa_ctrl.sv]
// controller state machine: clearing pass, scan, split, free check and merge
// depends on bpa_pkg; drives bpa_dp
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SRD, S_SCHK, S_SPLIT, S_FRD, S_FCHK,
        S_MTEST, S_MCHK, S_AFIN, S_FFIN, S_FAIL
    } t_state;

    t_state r_state, n_state;
    t_err   r_err, n_err;
    logic   r_ovalid, n_ovalid;
    logic   out_free;

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state   = r_state;
        n_err     = r_err;
        n_ovalid  = r_ovalid && !i_out_ready;
        o_cmd.op  = OP_NONE;
        o_cmd.err = r_err;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
                else o_cmd.op = OP_CLR;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.act) begin
                    if (i_sts.cnt_bad) begin
                        n_err   = ERR_NO_BLOCK;
                        n_state = S_FAIL;
                    end else begin
                        o_cmd.op = OP_INIT_A;
                        n_state  = S_SRD;
                    end
                end else begin
                    if (i_sts.addr_bad) begin
                        n_err   = ERR_BAD_ADDR;
                        n_state = S_FAIL;
                    end else begin
                        o_cmd.op = OP_INIT_F;
                        n_state  = S_FRD;
                    end
                end
            end
            S_SRD: begin
                o_cmd.op = OP_RD_IDX;
                n_state  = S_SCHK;
            end
            S_SCHK: begin
                priority if (i_sts.hit) begin
                    n_state = S_SPLIT;
                end else if (i_sts.scan_last) begin
                    n_err   = ERR_NO_BLOCK;
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = S_SRD;
                end
            end
            S_SPLIT: begin
                if (i_sts.split_done) n_state = S_AFIN;
                else o_cmd.op = OP_SPLIT;
            end
            S_FRD: begin
                o_cmd.op = OP_RD_IDX;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                if (!i_sts.used) begin
                    n_err   = ERR_NOT_ALLOC;
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_FREE_CLR;
                    n_state  = S_MTEST;
                end
            end
            S_MTEST: begin
                if (i_sts.top_max) begin
                    n_state = S_FFIN;
                end else begin
                    o_cmd.op = OP_RD_BUD;
                    n_state  = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_sts.hit) begin
                    o_cmd.op = OP_MERGE;
                    n_state  = S_MTEST;
                end else begin
                    n_state = S_FFIN;
                end
            end
            S_AFIN, S_FFIN, S_FAIL: begin
                // hold until the result register can take the beat
                if (out_free) begin
                    unique case (r_state)
                        S_AFIN:  o_cmd.op = OP_ALLOC_FIN;
                        S_FFIN:  o_cmd.op = OP_FREE_FIN;
                        default: o_cmd.op = OP_FAIL;
                    endcase
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_err    <= ERR_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

`default_nettype wire

[rtl/buddy_page_allocator.sv]
// top level of the buddy page allocator: stream ports, config register port
// depends on bpa_pkg, bpa_ctrl and bpa_dp
//
//   port group    dir   content
//   s_axis_*      in    request beat: tuser action, tdata page_count / free_address
//   m_axis_*      out   result beat: tuser ok / error_code, tdata address / order
//   i_cfg_*       in    region_base write, one cycle
//
// one request at a time; reads of the frame table are registered
// allocate: a scan for a free block, then splits; worst case about 2^(ORDERS+1) reads
// free: a check, then merges, at most ORDERS-1 of them
// after reset a clearing pass over all 2^ORDERS frames carves the region, no beat is taken
// a finished result waits in the output register while m_axis_tready is low;
// the next request is taken meanwhile, its result waits for that register
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [71:0]                   s_axis_tdata,  // page_count, free_address, pad
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [55:0]                   m_axis_tdata,  // block_address, block_order, pad
    output logic [2:0]                    m_axis_tuser   // ok, error_code
);
    import bpa_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic              ok;
    logic [1:0]        err;
    logic [ADDR_W-1:0] baddr;
    logic [ORD_W-1:0]  bord;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    bpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_act       (s_axis_tuser),
        .i_cnt       (s_axis_tdata[CNT_W-1:0]),
        .i_addr      (s_axis_tdata[CNT_W+ADDR_W-1:CNT_W]),
        .o_ok        (ok),
        .o_err       (err),
        .o_baddr     (baddr),
        .o_bord      (bord)
    );

    assign m_axis_tdata = {4'b0, bord, baddr};
    assign m_axis_tuser = {err, ok};

endmodule

`default_nettype wire

[rtl/bpa_checker.sv]
// port-level checks for the buddy page allocator, bound to the top level
// depends on bpa_pkg and the port list of buddy_page_allocator
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import bpa_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // success carries no error code
    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == ERR_NONE)
        else $error("ok with error code");

    // failure carries no error-free code and a zero block
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0
                                              && m_axis_tuser[2:1] != ERR_NONE)
        else $error("failed result with payload");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
